### rtl/btc_pkg.sv
// Shared types, constants and saturation helpers for the box terrain contact core.
`default_nettype none
package btc_pkg;

   localparam int BTC_MAX_VOLUMES = 4;
   localparam int MW   = 33;   // multiplier operand width
   localparam int PW   = 66;   // multiplier product width
   localparam int ACCW = 82;   // working accumulator width

   localparam logic signed [ACCW-1:0] LIM32_W = 82'sh7FFF_FFFF;
   localparam logic signed [ACCW-1:0] LIM48_W = 82'sh7FFF_FFFF_FFFF;
   localparam logic signed [ACCW-1:0] ONE30_W = 82'sd1073741824;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOAD = 5'b00010,
      S_MUL  = 5'b00100,
      S_ACC  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   // Micro operations, one multiply each, in execution order.
   typedef enum logic [5:0] {
      OP_R_XZ  = 6'd0,  OP_R_WY  = 6'd1,  OP_R_YZ  = 6'd2,  OP_R_WX  = 6'd3,
      OP_R_XX  = 6'd4,  OP_R_YY  = 6'd5,
      OP_D0    = 6'd6,  OP_D1    = 6'd7,  OP_D2    = 6'd8,
      OP_CR0   = 6'd9,  OP_CR1   = 6'd10, OP_CR2   = 6'd11, OP_CR3   = 6'd12,
      OP_CR4   = 6'd13, OP_CR5   = 6'd14,
      OP_PD0   = 6'd15, OP_PD1   = 6'd16, OP_PD2   = 6'd17,
      OP_F0    = 6'd18, OP_F1    = 6'd19,
      OP_FB0H  = 6'd20, OP_FB0L  = 6'd21, OP_FB1H  = 6'd22, OP_FB1L  = 6'd23,
      OP_FB2H  = 6'd24, OP_FB2L  = 6'd25,
      OP_M0AH  = 6'd26, OP_M0AL  = 6'd27, OP_M0BH  = 6'd28, OP_M0BL  = 6'd29,
      OP_M1AH  = 6'd30, OP_M1AL  = 6'd31, OP_M1BH  = 6'd32, OP_M1BL  = 6'd33,
      OP_M2AH  = 6'd34, OP_M2AL  = 6'd35, OP_M2BH  = 6'd36, OP_M2BL  = 6'd37
   } op_type;

   // Step request fields as seen by the engine.
   typedef struct packed {
      logic signed [31:0] height;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] velocity_down;
      logic signed [31:0] rate_roll;
      logic signed [31:0] rate_pitch;
      logic signed [31:0] rate_yaw;
   } step_in_type;

   typedef struct packed {
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
      logic signed [47:0] moment_x;
      logic signed [47:0] moment_y;
      logic signed [47:0] moment_z;
      logic               in_contact;
   } result_type;

   typedef struct packed {
      logic idle;
      logic load_out;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
      logic signed [ACCW-1:0] c;
      c = v;
      if (v > LIM32_W) c = LIM32_W;
      else if (v < -LIM32_W) c = -LIM32_W;
      return c[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [ACCW-1:0] v);
      logic signed [ACCW-1:0] c;
      c = v;
      if (v > LIM48_W) c = LIM48_W;
      else if (v < -LIM48_W) c = -LIM48_W;
      return c[47:0];
   endfunction

endpackage
`default_nettype wire

### rtl/btc_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module btc_mul
   import btc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic signed [MW-1:0]  mul_a,
   input  wire logic signed [MW-1:0]  mul_b,
   output logic signed [PW-1:0]       prod_ff
);

   // Product register, one operand pair per cycle.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule
`default_nettype wire

### rtl/btc_table.sv
// Volume table memory with one write port and one registered read port.
`default_nettype none
module btc_table
   import btc_pkg::*;
#(
   parameter int DEPTH = BTC_MAX_VOLUMES * 8,
   parameter int AW    = $clog2(BTC_MAX_VOLUMES * 8)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic signed [31:0]   wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output logic signed [31:0]        rd_data_ff
);

   logic signed [31:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/btc_engine.sv
// Sequencer and datapath that walk every corner through the shared multiplier.
`default_nettype none
module btc_engine
   import btc_pkg::*;
#(
   parameter int MAX_VOLUMES = BTC_MAX_VOLUMES,
   parameter int AW          = $clog2(BTC_MAX_VOLUMES * 8)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire step_in_type          step_in,
   input  wire logic [2:0]           vol_cfg,
   output logic [AW-1:0]             rd_addr,
   input  wire logic signed [31:0]   rd_data,
   output logic signed [MW-1:0]      mul_a,
   output logic signed [MW-1:0]      mul_b,
   input  wire logic signed [PW-1:0] prod,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output result_type                rsp,
   output status_type                stat
);

   localparam int VW = $clog2(MAX_VOLUMES + 1);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [VW-1:0] vol_ff, vol_in, nv;
   logic [2:0]    corner_ff, corner_in;
   logic [3:0]    ld_ff, ld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          contact_ff, contact_in;

   step_in_type   in_ff, in_in;
   result_type    rsp_ff, rsp_in;
   logic signed [31:0] row_ff [3];
   logic signed [31:0] row_in [3];
   logic signed [31:0] word_ff [8];
   logic signed [31:0] word_in [8];
   logic signed [31:0] cr_ff [3];
   logic signed [31:0] cr_in [3];
   logic signed [47:0] fb_ff [3];
   logic signed [47:0] fb_in [3];
   logic signed [47:0] f_ff [3];
   logic signed [47:0] f_in [3];
   logic signed [47:0] m_ff [3];
   logic signed [47:0] m_in [3];
   logic signed [31:0] pen_ff, pen_in, pd_ff, pd_in;
   logic signed [47:0] negf_ff, negf_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [63:0] tmp_ff, tmp_in;

   logic signed [31:0]     r [3];
   logic signed [31:0]     rate [3];
   logic signed [ACCW-1:0] p_ext;

   // Effective volume count.
   assign nv = (int'(vol_cfg) > MAX_VOLUMES) ? VW'(MAX_VOLUMES) : VW'(vol_cfg);

   assign rate[0] = in_ff.rate_roll;
   assign rate[1] = in_ff.rate_pitch;
   assign rate[2] = in_ff.rate_yaw;
   assign p_ext   = ACCW'(prod);
   assign rd_addr = AW'({vol_ff, ld_ff[2:0]});

   // Corner position of the current corner, offset plus or minus extent.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (corner_ff[2-k]) begin
            r[k] = sat32(ACCW'(word_ff[3+k]) - ACCW'(word_ff[k]));
         end else begin
            r[k] = sat32(ACCW'(word_ff[3+k]) + ACCW'(word_ff[k]));
         end
      end
   end

   function automatic logic signed [MW-1:0] hi48(input logic signed [47:0] v);
      return MW'($signed(v[47:24]));
   endfunction

   function automatic logic signed [MW-1:0] lo48(input logic signed [47:0] v);
      return MW'(v[23:0]);
   endfunction

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_R_XZ: begin mul_a = MW'(in_ff.quat_x); mul_b = MW'(in_ff.quat_z); end
         OP_R_WY: begin mul_a = MW'(in_ff.quat_w); mul_b = MW'(in_ff.quat_y); end
         OP_R_YZ: begin mul_a = MW'(in_ff.quat_y); mul_b = MW'(in_ff.quat_z); end
         OP_R_WX: begin mul_a = MW'(in_ff.quat_w); mul_b = MW'(in_ff.quat_x); end
         OP_R_XX: begin mul_a = MW'(in_ff.quat_x); mul_b = MW'(in_ff.quat_x); end
         OP_R_YY: begin mul_a = MW'(in_ff.quat_y); mul_b = MW'(in_ff.quat_y); end
         OP_D0:   begin mul_a = MW'(row_ff[0]); mul_b = MW'(r[0]); end
         OP_D1:   begin mul_a = MW'(row_ff[1]); mul_b = MW'(r[1]); end
         OP_D2:   begin mul_a = MW'(row_ff[2]); mul_b = MW'(r[2]); end
         OP_CR0:  begin mul_a = MW'(rate[1]); mul_b = MW'(r[2]); end
         OP_CR1:  begin mul_a = MW'(rate[2]); mul_b = MW'(r[1]); end
         OP_CR2:  begin mul_a = MW'(rate[2]); mul_b = MW'(r[0]); end
         OP_CR3:  begin mul_a = MW'(rate[0]); mul_b = MW'(r[2]); end
         OP_CR4:  begin mul_a = MW'(rate[0]); mul_b = MW'(r[1]); end
         OP_CR5:  begin mul_a = MW'(rate[1]); mul_b = MW'(r[0]); end
         OP_PD0:  begin mul_a = MW'(row_ff[0]); mul_b = MW'(cr_ff[0]); end
         OP_PD1:  begin mul_a = MW'(row_ff[1]); mul_b = MW'(cr_ff[1]); end
         OP_PD2:  begin mul_a = MW'(row_ff[2]); mul_b = MW'(cr_ff[2]); end
         OP_F0:   begin mul_a = MW'(word_ff[6]); mul_b = MW'(pen_ff); end
         OP_F1:   begin mul_a = MW'(word_ff[7]); mul_b = MW'(pd_ff); end
         OP_FB0H: begin mul_a = hi48(negf_ff); mul_b = MW'(row_ff[0]); end
         OP_FB0L: begin mul_a = lo48(negf_ff); mul_b = MW'(row_ff[0]); end
         OP_FB1H: begin mul_a = hi48(negf_ff); mul_b = MW'(row_ff[1]); end
         OP_FB1L: begin mul_a = lo48(negf_ff); mul_b = MW'(row_ff[1]); end
         OP_FB2H: begin mul_a = hi48(negf_ff); mul_b = MW'(row_ff[2]); end
         OP_FB2L: begin mul_a = lo48(negf_ff); mul_b = MW'(row_ff[2]); end
         OP_M0AH: begin mul_a = hi48(fb_ff[2]); mul_b = MW'(r[1]); end
         OP_M0AL: begin mul_a = lo48(fb_ff[2]); mul_b = MW'(r[1]); end
         OP_M0BH: begin mul_a = hi48(fb_ff[1]); mul_b = MW'(r[2]); end
         OP_M0BL: begin mul_a = lo48(fb_ff[1]); mul_b = MW'(r[2]); end
         OP_M1AH: begin mul_a = hi48(fb_ff[0]); mul_b = MW'(r[2]); end
         OP_M1AL: begin mul_a = lo48(fb_ff[0]); mul_b = MW'(r[2]); end
         OP_M1BH: begin mul_a = hi48(fb_ff[2]); mul_b = MW'(r[0]); end
         OP_M1BL: begin mul_a = lo48(fb_ff[2]); mul_b = MW'(r[0]); end
         OP_M2AH: begin mul_a = hi48(fb_ff[1]); mul_b = MW'(r[0]); end
         OP_M2AL: begin mul_a = lo48(fb_ff[1]); mul_b = MW'(r[0]); end
         OP_M2BH: begin mul_a = hi48(fb_ff[0]); mul_b = MW'(r[1]); end
         OP_M2BL: begin mul_a = lo48(fb_ff[0]); mul_b = MW'(r[1]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Sequencer and accumulation of each product.
   always_comb begin
      logic signed [ACCW-1:0] sum_t;
      logic signed [47:0]     fb_t;
      logic signed [31:0]     t32;
      logic                   next_corner;
      logic                   step_op;

      state_in     = state_ff;
      op_in        = op_ff;
      vol_in       = vol_ff;
      corner_in    = corner_ff;
      ld_in        = ld_ff;
      rsp_valid_in = rsp_valid_ff;
      contact_in   = contact_ff;
      in_in        = in_ff;
      rsp_in       = rsp_ff;
      row_in       = row_ff;
      word_in      = word_ff;
      cr_in        = cr_ff;
      fb_in        = fb_ff;
      f_in         = f_ff;
      m_in         = m_ff;
      pen_in       = pen_ff;
      pd_in        = pd_ff;
      negf_in      = negf_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      sum_t        = '0;
      fb_t         = '0;
      t32          = '0;
      next_corner  = 1'b0;
      step_op      = 1'b1;

      // The result register empties when the consumer takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               in_in      = step_in;
               contact_in = 1'b0;
               for (int k = 0; k < 3; k++) begin
                  f_in[k] = '0;
                  m_in[k] = '0;
               end
               op_in    = OP_R_XZ;
               state_in = S_MUL;
            end
         end

         S_LOAD: begin
            // One word address per cycle, data arrives in the next cycle.
            if (ld_ff != 4'd0) begin
               word_in[3'(ld_ff - 4'd1)] = rd_data;
            end
            ld_in = ld_ff + 4'd1;
            if (ld_ff == 4'd8) begin
               corner_in = '0;
               op_in     = OP_D0;
               state_in  = S_MUL;
            end
         end

         S_MUL: begin
            state_in = S_ACC;
         end

         S_ACC: begin
            case (op_ff)
               OP_R_XZ: acc_in = p_ext >>> 29;
               OP_R_WY: row_in[0] = sat32(acc_ff - (p_ext >>> 29));
               OP_R_YZ: acc_in = p_ext >>> 29;
               OP_R_WX: row_in[1] = sat32(acc_ff + (p_ext >>> 29));
               OP_R_XX: acc_in = ONE30_W - (p_ext >>> 29);
               OP_R_YY: begin
                  row_in[2] = sat32(acc_ff - (p_ext >>> 29));
                  step_op   = 1'b0;
                  if (nv == '0) begin
                     state_in = S_FIN;
                  end else begin
                     vol_in   = '0;
                     ld_in    = '0;
                     state_in = S_LOAD;
                  end
               end
               OP_D0: acc_in = p_ext >>> 30;
               OP_D1: acc_in = acc_ff + (p_ext >>> 30);
               OP_D2: begin
                  // Penetration below terrain; none means the corner is done.
                  sum_t = acc_ff + (p_ext >>> 30) - ACCW'(in_ff.height);
                  if (sum_t > 0) begin
                     pen_in     = sat32(sum_t);
                     contact_in = 1'b1;
                  end else begin
                     next_corner = 1'b1;
                  end
               end
               OP_CR0, OP_CR2, OP_CR4: acc_in = p_ext >>> 16;
               OP_CR1: cr_in[0] = sat32(acc_ff - (p_ext >>> 16));
               OP_CR3: cr_in[1] = sat32(acc_ff - (p_ext >>> 16));
               OP_CR5: cr_in[2] = sat32(acc_ff - (p_ext >>> 16));
               OP_PD0: acc_in = ACCW'(in_ff.velocity_down) + (p_ext >>> 30);
               OP_PD1: acc_in = acc_ff + (p_ext >>> 30);
               OP_PD2: begin
                  t32   = sat32(acc_ff + (p_ext >>> 30));
                  pd_in = (t32 < 0) ? 32'sd0 : t32;
               end
               OP_F0: acc_in = p_ext;
               OP_F1: negf_in = -sat48((acc_ff + p_ext) >>> 8);
               OP_FB0H, OP_FB1H, OP_FB2H,
               OP_M0AH, OP_M0BH, OP_M1AH, OP_M1BH, OP_M2AH, OP_M2BH:
                  acc_in = p_ext <<< 24;
               OP_FB0L: begin
                  fb_t     = sat48((acc_ff + p_ext) >>> 30);
                  fb_in[0] = fb_t;
                  f_in[0]  = sat48(ACCW'(f_ff[0]) + ACCW'(fb_t));
               end
               OP_FB1L: begin
                  fb_t     = sat48((acc_ff + p_ext) >>> 30);
                  fb_in[1] = fb_t;
                  f_in[1]  = sat48(ACCW'(f_ff[1]) + ACCW'(fb_t));
               end
               OP_FB2L: begin
                  fb_t     = sat48((acc_ff + p_ext) >>> 30);
                  fb_in[2] = fb_t;
                  f_in[2]  = sat48(ACCW'(f_ff[2]) + ACCW'(fb_t));
               end
               OP_M0AL, OP_M1AL, OP_M2AL: tmp_in = 64'((acc_ff + p_ext) >>> 16);
               OP_M0BL: begin
                  fb_t    = sat48(ACCW'(tmp_ff) - ((acc_ff + p_ext) >>> 16));
                  m_in[0] = sat48(ACCW'(m_ff[0]) + ACCW'(fb_t));
               end
               OP_M1BL: begin
                  fb_t    = sat48(ACCW'(tmp_ff) - ((acc_ff + p_ext) >>> 16));
                  m_in[1] = sat48(ACCW'(m_ff[1]) + ACCW'(fb_t));
               end
               OP_M2BL: begin
                  fb_t        = sat48(ACCW'(tmp_ff) - ((acc_ff + p_ext) >>> 16));
                  m_in[2]     = sat48(ACCW'(m_ff[2]) + ACCW'(fb_t));
                  next_corner = 1'b1;
               end
               default: acc_in = acc_ff;
            endcase

            // Advance to the next operation, corner or volume.
            if (next_corner) begin
               if (corner_ff == 3'd7) begin
                  if (vol_ff + 1'b1 == nv) begin
                     state_in = S_FIN;
                  end else begin
                     vol_in   = vol_ff + 1'b1;
                     ld_in    = '0;
                     state_in = S_LOAD;
                  end
               end else begin
                  corner_in = corner_ff + 3'd1;
                  op_in     = OP_D0;
                  state_in  = S_MUL;
               end
            end else if (step_op) begin
               op_in    = op_type'(op_ff + 6'd1);
               state_in = S_MUL;
            end
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.force_x    = f_ff[0];
               rsp_in.force_y    = f_ff[1];
               rsp_in.force_z    = f_ff[2];
               rsp_in.moment_x   = m_ff[0];
               rsp_in.moment_y   = m_ff[1];
               rsp_in.moment_z   = m_ff[2];
               rsp_in.in_contact = contact_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_R_XZ;
         vol_ff       <= '0;
         corner_ff    <= '0;
         ld_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         contact_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         vol_ff       <= vol_in;
         corner_ff    <= corner_in;
         ld_ff        <= ld_in;
         rsp_valid_ff <= rsp_valid_in;
         contact_ff   <= contact_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      rsp_ff  <= rsp_in;
      row_ff  <= row_in;
      word_ff <= word_in;
      cr_ff   <= cr_in;
      fb_ff   <= fb_in;
      f_ff    <= f_in;
      m_ff    <= m_in;
      pen_ff  <= pen_in;
      pd_ff   <= pd_in;
      negf_ff <= negf_in;
      acc_ff  <= acc_in;
      tmp_ff  <= tmp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;
   assign stat.idle     = (state_ff == S_IDLE);
   assign stat.load_out = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

endmodule
`default_nettype wire

### rtl/box_terrain_contact_forces_core.sv
// Top level of the box terrain contact force core.
// Penalty contact of box corners against terrain. A request with tuser = 1 writes one
// volume table word. A request with tuser = 0 runs a contact step through one shared
// 33x33 multiplier, each multiply passing a multiply state and an accumulate state:
// the attitude row first, then per volume a read of its eight words and per corner a
// depth test, plus the velocity, force and moment terms if the corner penetrates; the
// finish step then posts the result. The result waits in an output register, so a new
// request is taken while it is still pending.
`default_nettype none
module box_terrain_contact_forces_core
   import btc_pkg::*;
#(
   parameter int MAX_VOLUMES = BTC_MAX_VOLUMES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // Step or table write request.
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // height_above_terrain, quat_w, quat_x, quat_y, quat_z, velocity_down,
   // rate_roll, rate_pitch, rate_yaw, table_address, table_value, zero fill
   input  wire logic [327:0]  req_tdata,
   // op
   input  wire logic [0:0]    req_tuser,
   // Contact result.
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // force_x, force_y, force_z, moment_x, moment_y, moment_z, in_contact, zero fill
   output logic [295:0]       rsp_tdata,
   // Volume count register.
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_data
);

   localparam int TW = MAX_VOLUMES * 8;
   localparam int AW = $clog2(TW);

   logic                req_fire, start;
   logic                tbl_we;
   logic [AW-1:0]       rd_addr;
   logic signed [31:0]  rd_data;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic [2:0]          vol_cfg_ff;
   step_in_type         step_in;
   result_type          rsp;
   status_type          eng_stat;
   logic [4:0]          tbl_addr;

   assign req_fire  = req_tvalid && req_tready;
   assign start     = req_fire && !req_tuser[0];
   assign req_tready = eng_stat.idle;
   assign csr_ready = 1'b1;

   // Request unpacking.
   assign step_in.height        = req_tdata[31:0];
   assign step_in.quat_w        = req_tdata[63:32];
   assign step_in.quat_x        = req_tdata[95:64];
   assign step_in.quat_y        = req_tdata[127:96];
   assign step_in.quat_z        = req_tdata[159:128];
   assign step_in.velocity_down = req_tdata[191:160];
   assign step_in.rate_roll     = req_tdata[223:192];
   assign step_in.rate_pitch    = req_tdata[255:224];
   assign step_in.rate_yaw      = req_tdata[287:256];
   assign tbl_addr              = req_tdata[292:288];

   // Table writes beyond the table are dropped.
   assign tbl_we = req_fire && req_tuser[0] && (int'(tbl_addr) < TW);

   // Volume count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         vol_cfg_ff <= csr_data;
      end
   end

   btc_table #(.DEPTH(TW), .AW(AW)) u_table (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (AW'(tbl_addr)),
      .wr_data    (req_tdata[324:293]),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   btc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   btc_engine #(.MAX_VOLUMES(MAX_VOLUMES), .AW(AW)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .step_in   (step_in),
      .vol_cfg   (vol_cfg_ff),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .prod      (prod),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .stat      (eng_stat)
   );

   // Result packing.
   assign rsp_tdata = {7'b0, rsp.in_contact, rsp.moment_z, rsp.moment_y, rsp.moment_x,
                       rsp.force_z, rsp.force_y, rsp.force_x};

   // A step request keeps the core busy in the next cycle.
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> !req_tready)
      else $error("core idle right after a step request");

   // A table write leaves the core ready.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> req_tready)
      else $error("core busy after a table write");

   // A new result appears only from the finish step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(eng_stat.load_out))
      else $error("result posted outside the finish step");

endmodule
`default_nettype wire
